// ----- rtl/core/ipb_pkg.sv -----
// Package for the interval phase binner: widths, table geometry, shared types.
// No dependencies.
package ipb_pkg;
  localparam int SeriesCount = 256;
  localparam int EntriesPerSeries = 128;
  localparam int FirstSeries = 1;
  localparam int BinBits = 30;
  localparam int HalfBits = 15;
  localparam int FracBits = 16;
  localparam int AddrBits = 15;
  localparam int TableDepth = 1 << AddrBits;
  localparam int SlotBits = $clog2(EntriesPerSeries);
  localparam int TimeBits = 48;
  localparam int SecBits = 32;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                is_query;
    logic [AddrBits-1:0] addr;
    logic [SecBits-1:0]  seconds;
    logic [AddrBits-1:0] base;
    logic [TimeBits-1:0] now;
  } ipb_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_FIRST, ST_RD_LAST, ST_CHECK, ST_SCAN_RD, ST_SCAN_CMP,
    ST_PREV_RD, ST_DIV, ST_OUT
  } ipb_state_t;
endpackage

// ----- rtl/core/ipb_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module ipb_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/core/ipb_front.sv -----
// Front end: accepts requests, clamps the series and forms the row base.
// Depends on ipb_pkg.
module ipb_front import ipb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  input  logic                req_type,
  input  logic [AddrBits-1:0] entry_index,
  input  logic [SecBits-1:0]  entry_seconds,
  input  logic [7:0]          series_number,
  input  logic [TimeBits-1:0] now_time,
  output logic                q_valid,
  input  logic                q_ready,
  output ipb_cmd_t            q_cmd
);
  localparam int Depth = 2;
  ipb_cmd_t    fifo [Depth];
  logic        wp, rp;
  logic [1:0]  count;
  ipb_cmd_t    cmd;
  logic [8:0]  ser;
  logic [31:0] base_full;

  always_comb begin
    if ({1'b0, series_number} < 9'(FirstSeries)) ser = '0;
    else ser = {1'b0, series_number} - 9'(FirstSeries);
    if (ser > 9'(SeriesCount - 1)) ser = 9'(SeriesCount - 1);
    base_full = 32'(ser) * 32'(EntriesPerSeries);
    cmd.is_query = (req_type == REQ_QUERY);
    cmd.addr = entry_index;
    cmd.seconds = entry_seconds;
    cmd.base = base_full[AddrBits-1:0];
    cmd.now = now_time;
  end

  assign ready = (count != 2'(Depth));
  assign q_valid = (count != 2'd0);
  assign q_cmd = fifo[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (valid && ready) begin
        fifo[wp] <= cmd;
        wp <= ~wp;
      end
      if (q_valid && q_ready) rp <= ~rp;
      count <= count + 2'(valid && ready) - 2'(q_valid && q_ready);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'(Depth) |-> !ready) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(Depth)) else $error("queue count out of range");
  a_empty_idle: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !q_valid) else $error("empty queue presents");
`endif
endmodule

// ----- rtl/core/ipb_back.sv -----
// Back end: table writes, row search, bit-serial division, result register.
// Depends on ipb_pkg and ipb_ram.
module ipb_back import ipb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  ipb_cmd_t            q_cmd,
  output logic                valid,
  input  logic                ready,
  output logic                in_window,
  output logic [BinBits-1:0]  bin_value,
  output logic [HalfBits-1:0] high_part,
  output logic [HalfBits-1:0] low_part
);
  localparam logic [BinBits-1:0] Top = '1;
  localparam int DenBits = SecBits + FracBits + 1;

  ipb_state_t state, state_next;
  ipb_cmd_t   cur;
  logic [SecBits-1:0]  start_s, end_s;
  logic [SlotBits-1:0] slot;
  logic [5:0]          iter;
  logic [DenBits:0]    rem;
  logic [DenBits-1:0]  den;
  logic [BinBits-1:0]  quo;
  logic                res_win;
  logic [BinBits-1:0]  res_bin;

  logic                ram_we;
  logic [AddrBits-1:0] ram_addr;
  logic [SecBits-1:0]  rdata;

  ipb_ram #(.Width(SecBits), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(q_cmd.seconds), .rdata(rdata)
  );

  logic [TimeBits-1:0] rd_sh;
  logic [TimeBits-1:0] start_sh;
  logic [DenBits:0]    rem_sh;
  logic                slot_last;
  assign rd_sh = {rdata, {FracBits{1'b0}}};
  assign start_sh = {start_s, {FracBits{1'b0}}};
  assign rem_sh = {rem[DenBits-1:0], 1'b0};
  assign slot_last = (slot == SlotBits'(EntriesPerSeries - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = q_cmd.is_query ? ST_RD_FIRST : ST_IDLE;
      ST_RD_FIRST: state_next = ST_RD_LAST;
      ST_RD_LAST: state_next = ST_CHECK;
      ST_CHECK: begin
        if (cur.now < start_sh || cur.now >= rd_sh) state_next = ST_OUT;
        else state_next = ST_SCAN_RD;
      end
      ST_SCAN_RD: state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (cur.now < rd_sh) state_next = ST_PREV_RD;
        else if (slot_last) state_next = ST_DIV;
        else state_next = ST_SCAN_RD;
      end
      ST_PREV_RD: state_next = ST_DIV;
      ST_DIV: if (iter == 6'(BinBits)) state_next = ST_OUT;
      ST_OUT: if (!valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == ST_IDLE);
    ram_we = (state == ST_IDLE) && q_valid && !q_cmd.is_query;
    unique case (state)
      ST_IDLE: ram_addr = q_valid ? (q_cmd.is_query ? q_cmd.base : q_cmd.addr) : '0;
      ST_RD_FIRST, ST_RD_LAST: ram_addr = cur.base + AddrBits'(EntriesPerSeries - 1);
      ST_SCAN_RD: ram_addr = cur.base + AddrBits'(slot);
      ST_SCAN_CMP: ram_addr = cur.base + AddrBits'(slot) - AddrBits'(1);
      default: ram_addr = cur.base;
    endcase
  end

  logic [SecBits:0]   dur;
  logic [DenBits-1:0] den_v;
  logic [TimeBits-1:0] el;
  always_comb begin
    dur = {1'b0, end_s} - {1'b0, start_s};
    if (dur[SecBits] || dur == '0) dur = (SecBits+1)'(1);
    den_v = {dur[SecBits-1:0], {FracBits{1'b0}}, 1'b0} >> 1;
    el = cur.now - start_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      if (valid && ready) valid <= 1'b0;
      if (state == ST_OUT && !valid) valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (q_valid) cur <= q_cmd;
      ST_RD_FIRST: start_s <= rdata;
      ST_RD_LAST: ;
      ST_CHECK: begin
        end_s <= rdata;
        slot <= SlotBits'(1);
        res_win <= 1'b0;
        res_bin <= '0;
      end
      ST_SCAN_RD: ;
      ST_SCAN_CMP: begin
        if (cur.now < rd_sh) end_s <= rdata;
        else slot <= slot + SlotBits'(1);
        iter <= '0;
      end
      ST_PREV_RD: start_s <= rdata;
      ST_DIV: begin
        if (iter == '0) begin
          den <= den_v;
          rem <= (DenBits+1)'(el);
          quo <= '0;
          iter <= 6'd1;
        end else if (iter <= 6'(BinBits)) begin
          if (iter == 6'(BinBits)) begin
            res_win <= 1'b1;
            res_bin <= ({1'b0, el} >= {1'b0, den}) ? Top :
                       {quo[BinBits-2:0], rem_sh >= {1'b0, den}};
          end else begin
            quo <= {quo[BinBits-2:0], rem_sh >= {1'b0, den}};
            rem <= (rem_sh >= {1'b0, den}) ? rem_sh - {1'b0, den} : rem_sh;
            iter <= iter + 6'd1;
          end
        end
      end
      ST_OUT: if (!valid) begin
        in_window <= res_win;
        bin_value <= res_bin;
        high_part <= HalfBits'(res_bin >> HalfBits);
        low_part <= res_bin[HalfBits-1:0];
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_IDLE) else $error("table write while busy");
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !in_window |-> bin_value == '0) else $error("bin outside window");
  a_split: assert property (@(posedge clk) disable iff (rst)
    valid |-> low_part == bin_value[HalfBits-1:0]) else $error("bad low part");
`endif
endmodule

// ----- rtl/core/interval_phase_binner_unit.sv -----
// Interval phase binner top level: front queue and back-end search/divide.
// Depends on ipb_pkg, ipb_front, ipb_back.
//
// channel | signals                                        | dir
// request | valid/ready, req_type..now_time                | in
// result  | out_valid/out_ready, in_window..low_part       | out
//
// A load is written to the table while the back end stays idle. A query outside
// its window goes through the first and last row reads and the window check to
// its result; one inside also scans the row through the single table port and
// runs the bit-serial divide. Two requests queue ahead of the back end. Reset
// clears control only; table contents are undefined until written. A result held
// by out_ready stalls the back end at the next query result; the queue fills.
module interval_phase_binner_unit import ipb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  input  logic                req_type,
  input  logic [AddrBits-1:0] entry_index,
  input  logic [SecBits-1:0]  entry_seconds,
  input  logic [7:0]          series_number,
  input  logic [TimeBits-1:0] now_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                in_window,
  output logic [BinBits-1:0]  bin_value,
  output logic [HalfBits-1:0] high_part,
  output logic [HalfBits-1:0] low_part
);
  logic     q_valid, q_ready;
  ipb_cmd_t q_cmd;

  ipb_front u_front (
    .clk, .rst, .valid, .ready, .req_type, .entry_index, .entry_seconds,
    .series_number, .now_time, .q_valid, .q_ready, .q_cmd
  );

  ipb_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd, .valid(out_valid), .ready(out_ready),
    .in_window, .bin_value, .high_part, .low_part
  );
endmodule
